// ===== hdl/ucdw_pkg.sv =====
// ----------------------------------------------------------------------------
// ucdw_pkg: shared types and codes of the configuration descriptor walker
// Payload structs of both channels, the parse-to-output queue entry, record
// type codes, result kinds and record length limits.
// ----------------------------------------------------------------------------
package ucdw_pkg;

  // Result kinds
  localparam logic [2:0] KIND_CONFIG      = 3'd0;
  localparam logic [2:0] KIND_INTERFACE   = 3'd1;
  localparam logic [2:0] KIND_ENDPOINT    = 3'd2;
  localparam logic [2:0] KIND_END_OK      = 3'd3;
  localparam logic [2:0] KIND_END_INVALID = 3'd4;

  // Descriptor type codes
  localparam logic [7:0] TYPE_CONFIG    = 8'd2;
  localparam logic [7:0] TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;

  // Record length limits
  localparam logic [7:0] LEN_MIN      = 8'd2;
  localparam logic [7:0] LEN_FULL     = 8'd9;
  localparam logic [7:0] LEN_EP_SHORT = 8'd7;

  // Record bytes 2..8 are captured
  localparam int          CAPTURE_DEPTH = 7;
  localparam logic [7:0]  CAPTURE_FIRST = 8'd2;
  localparam logic [7:0]  CAPTURE_END   = 8'd9;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_blob;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  rec_kind;
    logic [7:0]  id_value;
    logic [7:0]  attributes;
    logic [7:0]  alt_setting;
    logic [7:0]  class_code;
    logic [7:0]  subclass_code;
    logic [7:0]  protocol_code;
    logic [7:0]  string_index;
    logic [7:0]  power_or_interval;
    logic [15:0] max_packet_size;
    logic [7:0]  owner_interface;
    logic        is_last;
  } rec_item_t;

  // One parsed byte's worth of results: an optional record, an optional end
  typedef struct packed {
    logic      has_rec;
    rec_item_t rec;
    logic      has_end;
    logic      end_bad;
  } q_entry_t;

endpackage

// ===== hdl/ucdw_front.sv =====
// ----------------------------------------------------------------------------
// ucdw_front: byte parser
// Accepts one blob byte per cycle while accept is high, tracks skip and record position, captures
// record bytes and classifies finished records into queue entries.
// ----------------------------------------------------------------------------
module ucdw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  ucdw_pkg::byte_item_t item,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  output logic               push,
  output ucdw_pkg::q_entry_t entry
);
  import ucdw_pkg::*;

  logic [15:0] skip_count;
  logic [15:0] skip_left, skip_left_next;
  logic [7:0]  byte_pos, byte_pos_next;
  logic [7:0]  rec_length, rec_length_next;
  logic [7:0]  rec_type, rec_type_next;
  logic [7:0]  cap [CAPTURE_DEPTH];
  logic        have_config, have_config_next;
  logic        have_interface, have_interface_next;
  logic [7:0]  current_interface, current_interface_next;
  logic        stopped, stopped_next;
  logic        failed, failed_next;

  logic [7:0]  b;
  logic [7:0]  pos_inc;
  logic [7:0]  type_eff;
  logic [2:0]  cap_idx;
  logic        cap_we;
  logic [7:0]  c [CAPTURE_DEPTH];
  logic        rec_fire;
  rec_item_t   rec;
  logic        end_bad;

  assign b       = item.data_byte;
  assign pos_inc = byte_pos + 8'd1;
  assign cap_idx = 3'(byte_pos - CAPTURE_FIRST);
  // the type byte may arrive on the same cycle as a two-byte record ends
  assign type_eff = (byte_pos == 8'd1) ? b : rec_type;

  always_comb begin
    skip_left_next         = skip_left;
    byte_pos_next          = byte_pos;
    rec_length_next        = rec_length;
    rec_type_next          = rec_type;
    have_config_next       = have_config;
    have_interface_next    = have_interface;
    current_interface_next = current_interface;
    stopped_next           = stopped;
    failed_next            = failed;
    cap_we                 = 1'b0;
    rec_fire               = 1'b0;
    rec                    = '0;
    end_bad                = 1'b0;
    for (int i = 0; i < CAPTURE_DEPTH; i++) begin
      c[i] = cap[i];
    end

    if (accept && !stopped) begin
      if (skip_left != 16'd0) begin
        skip_left_next = skip_left - 16'd1;
      end else if (byte_pos == 8'd0 && b < LEN_MIN) begin
        // short length: stop with ok status
        rec_length_next = b;
        stopped_next    = 1'b1;
      end else begin
        if (byte_pos == 8'd0) begin
          rec_length_next = b;
        end
        if (byte_pos == 8'd1) begin
          rec_type_next = b;
        end
        if (byte_pos >= CAPTURE_FIRST && byte_pos < CAPTURE_END) begin
          cap_we     = 1'b1;
          c[cap_idx] = b;
        end
        byte_pos_next = pos_inc;
        if (pos_inc >= LEN_MIN && pos_inc == rec_length) begin
          byte_pos_next = 8'd0;
          unique if (type_eff == TYPE_CONFIG) begin
            if (rec_length != LEN_FULL) begin
              stopped_next = 1'b1;
              failed_next  = 1'b1;
            end else begin
              have_config_next      = 1'b1;
              have_interface_next   = 1'b0;
              rec_fire              = 1'b1;
              rec.rec_kind          = KIND_CONFIG;
              rec.id_value          = c[3];
              rec.attributes        = c[5];
              rec.string_index      = c[4];
              rec.power_or_interval = c[6];
            end
          end else if (type_eff == TYPE_INTERFACE) begin
            if (rec_length != LEN_FULL || !have_config) begin
              stopped_next = 1'b1;
              failed_next  = 1'b1;
            end else begin
              have_interface_next    = 1'b1;
              current_interface_next = c[0];
              rec_fire               = 1'b1;
              rec.rec_kind           = KIND_INTERFACE;
              rec.id_value           = c[0];
              rec.alt_setting        = c[1];
              rec.class_code         = c[3];
              rec.subclass_code      = c[4];
              rec.protocol_code      = c[5];
              rec.string_index       = c[6];
            end
          end else if (type_eff == TYPE_ENDPOINT) begin
            if ((rec_length != LEN_EP_SHORT && rec_length != LEN_FULL) || !have_interface) begin
              stopped_next = 1'b1;
              failed_next  = 1'b1;
            end else begin
              rec_fire              = 1'b1;
              rec.rec_kind          = KIND_ENDPOINT;
              rec.id_value          = c[0];
              rec.attributes        = c[1];
              rec.power_or_interval = c[4];
              rec.max_packet_size   = {c[3], c[2]};
              rec.owner_interface   = current_interface;
            end
          end else begin
            // other types: skip whole
          end
        end
      end
    end

    if (accept && item.end_of_blob) begin
      end_bad                = failed_next;
      // clear the walk for the next blob
      skip_left_next         = skip_count;
      byte_pos_next          = 8'd0;
      rec_length_next        = 8'd0;
      rec_type_next          = 8'd0;
      have_config_next       = 1'b0;
      have_interface_next    = 1'b0;
      current_interface_next = 8'd0;
      stopped_next           = 1'b0;
      failed_next            = 1'b0;
    end
  end

  assign push          = accept && (rec_fire || item.end_of_blob);
  assign entry.has_rec = rec_fire;
  assign entry.rec     = rec;
  assign entry.has_end = item.end_of_blob;
  assign entry.end_bad = end_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count        <= 16'd0;
      skip_left         <= 16'd0;
      byte_pos          <= 8'd0;
      rec_length        <= 8'd0;
      rec_type          <= 8'd0;
      have_config       <= 1'b0;
      have_interface    <= 1'b0;
      current_interface <= 8'd0;
      stopped           <= 1'b0;
      failed            <= 1'b0;
    end else begin
      skip_left         <= skip_left_next;
      byte_pos          <= byte_pos_next;
      rec_length        <= rec_length_next;
      rec_type          <= rec_type_next;
      have_config       <= have_config_next;
      have_interface    <= have_interface_next;
      current_interface <= current_interface_next;
      stopped           <= stopped_next;
      failed            <= failed_next;
      if (cfg_wr_en) begin
        skip_count <= cfg_wr_data;
        skip_left  <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap[cap_idx] <= b;
    end
  end

endmodule

// ===== hdl/ucdw_queue.sv =====
// ----------------------------------------------------------------------------
// ucdw_queue: parse-to-output queue
// Small FIFO of parsed entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module ucdw_queue #(
  parameter int DEPTH = ucdw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ucdw_pkg::q_entry_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output ucdw_pkg::q_entry_t head
);
  import ucdw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/ucdw_back.sv =====
// ----------------------------------------------------------------------------
// ucdw_back: result output stage
// Holds one queue entry and hands out its record result, then its final
// status result, one per cycle while rec_stall is low.
// ----------------------------------------------------------------------------
module ucdw_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  ucdw_pkg::q_entry_t q_head,
  output logic               q_pop,
  output logic               rec_valid,
  input  logic               rec_stall,
  output ucdw_pkg::rec_item_t rec_data
);
  import ucdw_pkg::*;

  q_entry_t  cur;
  logic      rec_pend;
  logic      end_pend;
  logic      taking;
  logic      last_taken;
  rec_item_t end_rec;

  assign rec_valid  = rec_pend || end_pend;
  assign taking     = rec_valid && !rec_stall;
  // the held entry runs dry on this edge
  assign last_taken = taking && !(rec_pend && end_pend);
  assign q_pop      = q_not_empty && (!rec_valid || last_taken);

  always_comb begin
    end_rec          = '0;
    end_rec.rec_kind = cur.end_bad ? KIND_END_INVALID : KIND_END_OK;
    end_rec.is_last  = 1'b1;
  end

  assign rec_data = rec_pend ? cur.rec : end_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_pend <= 1'b0;
      end_pend <= 1'b0;
    end else if (q_pop) begin
      rec_pend <= q_head.has_rec;
      end_pend <= q_head.has_end;
    end else if (taking) begin
      if (rec_pend) begin
        rec_pend <= 1'b0;
      end else begin
        end_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

endmodule

// ===== hdl/usb_config_descriptor_walker.sv =====
// ----------------------------------------------------------------------------
// usb_config_descriptor_walker: configuration descriptor walker
// Parses a configuration descriptor blob byte by byte into config,
// interface, endpoint and final status records.
// ----------------------------------------------------------------------------
// The walker takes one blob byte per clock (byte_valid/byte_stall) with no
// gaps of its own: the parser settles each byte in the cycle it is accepted.
// It first drops skip_count leading bytes, then walks length-type records.
// Configuration and interface records must be 9 bytes long and endpoint
// records 7 or 9; other types are skipped. Each good record yields one
// result; the byte flagged end_of_blob also yields a final status result
// (is_last set) after any record result of that byte, and the walk then
// restarts for the next blob with skip_count reloaded. A length or order
// error stops parsing and marks the blob invalid; a length below 2 or a
// record cut off by the end of the blob stops it with ok status. Results
// leave at most one per clock through an output register, so a byte that
// ends both a record and the blob occupies the result port for two results;
// a queue of QUEUE_DEPTH parsed entries between the parser and the output
// stage absorbs this and output stalls, and byte_stall rises only when that
// queue is full. A result passes through a queue slot, then the output register.
// Write skip_count through cfg_wr_en/cfg_wr_data only while idle; a write
// also reloads the skip counter. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module usb_config_descriptor_walker #(
  parameter int QUEUE_DEPTH = ucdw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  ucdw_pkg::byte_item_t byte_data,
  output logic                rec_valid,
  input  logic                rec_stall,
  output ucdw_pkg::rec_item_t rec_data,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);
  import ucdw_pkg::*;

  logic     accept;
  logic     push;
  q_entry_t entry;
  logic     q_full;
  logic     q_not_empty;
  logic     q_pop;
  q_entry_t q_head;

  // hold the input only when the queue has no room for another entry
  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;

  ucdw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (byte_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .entry      (entry)
  );

  ucdw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(entry),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  ucdw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .rec_data   (rec_data)
  );

endmodule
